### hdl/psdq_pkg.sv
`default_nettype none
package psdq_pkg;
   localparam int EntryDepthDefault   = 64;
   localparam int PayloadBytesDefault = 1024;

   typedef enum logic [2:0] {
      KIND_PAYLOAD_BYTE = 3'd0,
      KIND_PUSH         = 3'd1,
      KIND_POP          = 3'd2,
      KIND_PEEK         = 3'd3,
      KIND_SORT         = 3'd4,
      KIND_CLEAR        = 3'd5,
      KIND_READ_BYTE    = 3'd6,
      KIND_NONE         = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // one descriptor word: type, priority, offset, size
   localparam int DescWidth = 16 + 16 + 11 + 11;

   typedef struct packed {
      logic [15:0] entry_type;
      logic [15:0] entry_priority;
      logic [10:0] entry_offset;
      logic [10:0] entry_size;
   } desc_type;
endpackage
`default_nettype wire

### hdl/priority_sorted_dispatch_queue.sv
`default_nettype none
// Channel | Dir | tdata fields (low bit first)                        | tuser
// req     | in  | data_byte, type_id, priority_req, entry_index,       | kind
//         |     | byte_address (56 bits)                               |
// rsp     | out | status, entry_type, entry_priority, entry_offset,    | -
//         |     | entry_size, byte_out, unread_count (71 bits -> 72)   |
// One transfer in gives one transfer out. payload_byte, push, clear, unused kind and
// a sort with under two unread entries: result registered at the accepting edge.
// pop, peek, read_byte: the RAM read is issued in ST_RD and the result registered
// in ST_RESP. sort steps, set by the single descriptor RAM port pair:
// ST_KWAIT, ST_SKEY, ST_SWAIT, ST_SCMP per outer step; ST_SWAIT, ST_SCMP again per
// element moved; ST_SPUT as well when the key lands at the read pointer.
// Reset is synchronous and clears state, counters and rsp_tvalid; RAM contents are undefined.
// A stalled rsp holds its payload; req is taken only while idle and no rsp is pending.
module priority_sorted_dispatch_queue
   import psdq_pkg::*;
#(
   parameter int ENTRY_DEPTH   = EntryDepthDefault,
   parameter int PAYLOAD_BYTES = PayloadBytesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [2:0]  req_tuser,  // kind
   input  wire logic [55:0] req_tdata,  // data_byte, type_id, priority_req,
                                        // entry_index, byte_address
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata   // status, entry_type, entry_priority,
                                        // entry_offset, entry_size, byte_out,
                                        // unread_count
);
   localparam int EA = $clog2(ENTRY_DEPTH);
   localparam int PA = $clog2(PAYLOAD_BYTES);
   localparam int CW = $clog2(ENTRY_DEPTH + 1);   // entry counters
   localparam int LW = $clog2(PAYLOAD_BYTES + 1); // payload lengths

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_RD    = 8'b00000010,  // descriptor / payload read issued
      ST_RESP  = 8'b00000100,
      ST_SKEY  = 8'b00001000,  // sort: key read returned
      ST_SCMP  = 8'b00010000,  // sort: neighbour read returned
      ST_SWAIT = 8'b00100000,  // sort: wait for neighbour read
      ST_KWAIT = 8'b01000000,  // sort: wait for key read
      ST_SPUT  = 8'b10000000   // sort: key goes to the read pointer slot
   } state_type;

   state_type state_ff, state_in;

   // request fields
   logic [2:0]  kind;
   logic [7:0]  data_byte;
   logic [15:0] type_id, priority_req;
   logic [5:0]  entry_index;
   logic [9:0]  byte_address;
   assign kind         = req_tuser;
   assign data_byte    = req_tdata[7:0];
   assign type_id      = req_tdata[23:8];
   assign priority_req = req_tdata[39:24];
   assign entry_index  = req_tdata[45:40];
   assign byte_address = req_tdata[55:46];

   logic [CW-1:0] count_ff, count_in, rptr_ff, rptr_in;
   logic [LW-1:0] comm_ff, comm_in, stg_ff, stg_in;
   logic [2:0]  kind_ff, kind_in;
   logic [EA-1:0] idx_ff, idx_in;
   logic [PA-1:0] addr_ff, addr_in;
   logic        busy_range_ff, busy_range_in; // request address/index was valid

   // sort loop
   logic [CW-1:0] si_ff, si_in, sj_ff, sj_in;
   desc_type    key_ff, key_in;

   // response register
   logic        rv_ff, rv_in;
   logic [71:0] rd_ff, rd_in;

   // descriptor RAM
   logic          d_we;
   logic [EA-1:0] d_wa, d_ra;
   desc_type      d_wd, d_rd;
   // payload RAM
   logic          p_we;
   logic [PA-1:0] p_wa, p_ra;
   logic [7:0]    p_rd;

   psdq_ram #(.Width(DescWidth), .Depth(ENTRY_DEPTH)) u_desc_ram (
      .clock(clock), .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra), .rd_data(d_rd));

   psdq_ram #(.Width(8), .Depth(PAYLOAD_BYTES)) u_payload_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(data_byte),
      .rd_addr(p_ra), .rd_data(p_rd));

   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   logic accept;
   assign accept = req_tvalid && req_tready;

   function automatic logic [71:0] pack_rsp(input logic [1:0] st, input desc_type d,
                                             input logic [7:0] b,
                                             input logic [6:0] un);
      pack_rsp = {1'b0, un, b, d.entry_size, d.entry_offset, d.entry_priority,
                  d.entry_type, st};
   endfunction

   // unread count from the registered pointers; push adds its own entry
   logic [6:0]  unread;
   logic [LW:0] ppos;
   assign unread = 7'((count_ff - rptr_ff));
   assign ppos   = (LW+1)'(comm_ff) + (LW+1)'(stg_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff; rptr_in = rptr_ff; comm_in = comm_ff; stg_in = stg_ff;
      kind_in = kind_ff; idx_in = idx_ff; addr_in = addr_ff;
      busy_range_in = busy_range_ff;
      si_in = si_ff; sj_in = sj_ff; key_in = key_ff;
      rv_in = rv_ff && !rsp_tready; rd_in = rd_ff;
      d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = idx_ff;
      p_we = 1'b0; p_wa = ppos[PA-1:0]; p_ra = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = kind;
               unique case (kind)
                  KIND_PAYLOAD_BYTE: begin
                     if (ppos < (LW+1)'(PAYLOAD_BYTES)) begin
                        p_we   = 1'b1;
                        stg_in = stg_ff + 1'b1;
                        rd_in  = pack_rsp(STATUS_OK, '0, '0, unread);
                     end else begin
                        rd_in  = pack_rsp(STATUS_FULL, '0, '0, unread);
                     end
                     rv_in = 1'b1;
                  end
                  KIND_PUSH: begin
                     stg_in = '0;
                     if (count_ff < CW'(ENTRY_DEPTH)) begin
                        d_we = 1'b1; d_wa = count_ff[EA-1:0];
                        d_wd = '{type_id, priority_req, 11'(comm_ff), 11'(stg_ff)};
                        comm_in  = comm_ff + stg_ff;
                        count_in = count_ff + 1'b1;
                        rd_in = pack_rsp(STATUS_OK, d_wd, '0,
                                         7'((count_ff - rptr_ff) + 1'b1));
                     end else begin
                        rd_in = pack_rsp(STATUS_FULL, '0, '0, unread);
                     end
                     rv_in = 1'b1;
                  end
                  KIND_POP: begin
                     busy_range_in = rptr_ff < count_ff;
                     idx_in = rptr_ff[EA-1:0];
                     if (rptr_ff < count_ff) rptr_in = rptr_ff + 1'b1;
                     state_in = ST_RD;
                  end
                  KIND_PEEK: begin
                     busy_range_in = (CW'(entry_index) < count_ff) &&
                                     (32'(entry_index) < ENTRY_DEPTH);
                     idx_in = EA'(entry_index);
                     state_in = ST_RD;
                  end
                  KIND_READ_BYTE: begin
                     busy_range_in = 32'(byte_address) < PAYLOAD_BYTES;
                     addr_in = PA'(byte_address);
                     state_in = ST_RD;
                  end
                  KIND_SORT: begin
                     si_in = rptr_ff + 1'b1;
                     if (rptr_ff + 1'b1 < count_ff) begin
                        idx_in = EA'(rptr_ff + 1'b1);
                        state_in = ST_KWAIT;
                     end else begin
                        rd_in = pack_rsp(STATUS_OK, '0, '0, unread);
                        rv_in = 1'b1;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0; rptr_in = '0; comm_in = '0; stg_in = '0;
                     rd_in = pack_rsp(STATUS_OK, '0, '0, 7'd0);
                     rv_in = 1'b1;
                  end
                  default: begin
                     rd_in = pack_rsp(STATUS_OK, '0, '0, unread);
                     rv_in = 1'b1;
                  end
               endcase
            end
         end
         ST_RD: state_in = ST_RESP;  // RAM read in flight
         ST_RESP: begin
            if (!busy_range_ff)
               rd_in = pack_rsp(STATUS_EMPTY, '0, '0, unread);
            else if (kind_ff == KIND_READ_BYTE)
               rd_in = pack_rsp(STATUS_OK, '0, p_rd, unread);
            else
               rd_in = pack_rsp(STATUS_OK, d_rd, '0, unread);
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_KWAIT: begin
            // read of slot si issued here (d_ra = idx_ff)
            state_in = ST_SKEY;
         end
         ST_SKEY: begin
            key_in = d_rd;
            sj_in  = si_ff;
            idx_in = EA'(si_ff - 1'b1);
            state_in = ST_SWAIT;
         end
         ST_SWAIT: state_in = ST_SCMP;
         ST_SCMP: begin
            // d_rd holds slot sj-1
            if ($signed(d_rd.entry_priority) > $signed(key_ff.entry_priority)) begin
               d_we = 1'b1; d_wa = sj_ff[EA-1:0]; d_wd = d_rd;
               sj_in = sj_ff - 1'b1;
               if (sj_ff - 1'b1 > rptr_ff) begin
                  idx_in = EA'(sj_ff - 2'd2);
                  state_in = ST_SWAIT;
               end else begin
                  state_in = ST_SPUT;  // write port busy with the shift
               end
            end else begin
               // place the key and move to the next element
               d_we = 1'b1; d_wa = sj_ff[EA-1:0]; d_wd = key_ff;
               if (si_ff + 1'b1 < count_ff) begin
                  si_in = si_ff + 1'b1;
                  idx_in = EA'(si_ff + 1'b1);
                  state_in = ST_KWAIT;
               end else begin
                  rd_in = pack_rsp(STATUS_OK, '0, '0, unread);
                  rv_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SPUT: begin
            d_we = 1'b1; d_wa = sj_ff[EA-1:0]; d_wd = key_ff;
            if (si_ff + 1'b1 < count_ff) begin
               si_in = si_ff + 1'b1;
               idx_in = EA'(si_ff + 1'b1);
               state_in = ST_KWAIT;
            end else begin
               rd_in = pack_rsp(STATUS_OK, '0, '0, unread);
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0; rptr_ff <= '0; comm_ff <= '0; stg_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in; rptr_ff <= rptr_in;
         comm_ff <= comm_in; stg_ff <= stg_in;
         rv_ff <= rv_in;
      end
      kind_ff <= kind_in; idx_ff <= idx_in; addr_ff <= addr_in;
      busy_range_ff <= busy_range_in;
      si_ff <= si_in; sj_ff <= sj_in; key_ff <= key_in;
      rd_ff <= rd_in;
   end
endmodule
`default_nettype wire

### hdl/psdq_ram.sv
`default_nettype none
module psdq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### hdl/psdq_checker.sv
`default_nettype none
module psdq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed under stall");
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("req taken with result pending");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("bad status");
   a_unread_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[70:64] <= 7'd64)
      else $error("unread count beyond depth");
endmodule

bind priority_sorted_dispatch_queue psdq_checker u_psdq_checker (.*);
`default_nettype wire

### tb/sv/priority_sorted_dispatch_queue_test.sv
`default_nettype none
module priority_sorted_dispatch_queue_test;
   import psdq_pkg::*;

   localparam int Depth = EntryDepthDefault;
   localparam int PayBytes = PayloadBytesDefault;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] entry_type;
      logic [15:0] entry_priority;
      logic [10:0] entry_offset;
      logic [10:0] entry_size;
      logic [7:0]  byte_out;
      logic [6:0]  unread_count;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [2:0]  req_tuser = '0;
   logic [55:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   always #2 clock = ~clock;

   priority_sorted_dispatch_queue u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // shadow of the queue state
   logic [15:0] sh_type [Depth];
   logic [15:0] sh_prio [Depth];
   logic [10:0] sh_off  [Depth];
   logic [10:0] sh_size [Depth];
   logic [7:0]  sh_pay  [PayBytes];
   int sh_count, sh_rd, sh_committed, sh_staged;

   // pending item word: kind in [2:0], then the tdata fields from bit 3
   logic [63:0] pending_items [$];
   outcome_type expected_rsp [$];
   int errors = 0;
   int sent = 0, received = 0;
   int full_hits = 0, sorts = 0;
   bit hold_rsp = 1'b0;
   bit stim_done = 1'b0;

   function automatic logic [63:0] pack_item(kind_type k, logic [7:0] d, logic [15:0] t,
                                             logic [15:0] p, logic [5:0] i, logic [9:0] a);
      return {5'd0, a, i, p, t, d, k};
   endfunction

   function automatic outcome_type unpack_rsp(logic [71:0] w);
      outcome_type o;
      o.status         = w[1:0];
      o.entry_type     = w[17:2];
      o.entry_priority = w[33:18];
      o.entry_offset   = w[44:34];
      o.entry_size     = w[55:45];
      o.byte_out       = w[63:56];
      o.unread_count   = w[70:64];
      return o;
   endfunction

   // stable insertion sort over the unread slots
   task automatic sort_unread_entries();
      int j;
      logic [15:0] kt, kp;
      logic [10:0] ko, ks;
      for (int i = sh_rd + 1; i < sh_count; i++) begin
         kt = sh_type[i]; kp = sh_prio[i]; ko = sh_off[i]; ks = sh_size[i];
         j = i;
         while (j > sh_rd && $signed(sh_prio[j-1]) > $signed(kp)) begin
            sh_type[j] = sh_type[j-1]; sh_prio[j] = sh_prio[j-1];
            sh_off[j] = sh_off[j-1]; sh_size[j] = sh_size[j-1];
            j--;
         end
         sh_type[j] = kt; sh_prio[j] = kp; sh_off[j] = ko; sh_size[j] = ks;
      end
   endtask

   function automatic void show_entry(ref outcome_type o, input int slot);
      o.entry_type = sh_type[slot];
      o.entry_priority = sh_prio[slot];
      o.entry_offset = sh_off[slot];
      o.entry_size = sh_size[slot];
   endfunction

   task automatic predict_dispatch(input logic [63:0] w);
      outcome_type o;
      kind_type k;
      int slot, addr;
      o = '0;
      k = kind_type'(w[2:0]);
      slot = int'(w[48:43]);
      addr = int'(w[58:49]);
      case (k)
         KIND_PAYLOAD_BYTE: begin
            if (sh_committed + sh_staged < PayBytes) begin
               sh_pay[sh_committed + sh_staged] = w[10:3];
               sh_staged++;
            end else begin
               o.status = STATUS_FULL;
               full_hits++;
            end
         end
         KIND_PUSH: begin
            if (sh_count < Depth) begin
               sh_type[sh_count] = w[26:11];
               sh_prio[sh_count] = w[42:27];
               sh_off[sh_count] = 11'(sh_committed);
               sh_size[sh_count] = 11'(sh_staged);
               show_entry(o, sh_count);
               sh_committed += sh_staged;
               sh_count++;
            end else begin
               o.status = STATUS_FULL;
               full_hits++;
            end
            sh_staged = 0;
         end
         KIND_POP: begin
            if (sh_rd < sh_count) begin
               show_entry(o, sh_rd);
               sh_rd++;
            end else begin
               o.status = STATUS_EMPTY;
            end
         end
         KIND_PEEK: begin
            if (slot < sh_count) show_entry(o, slot);
            else o.status = STATUS_EMPTY;
         end
         KIND_SORT: begin
            sort_unread_entries();
            sorts++;
         end
         KIND_CLEAR: begin
            sh_count = 0; sh_rd = 0; sh_committed = 0; sh_staged = 0;
         end
         KIND_READ_BYTE: begin
            if (addr < PayBytes) o.byte_out = sh_pay[addr];
            else o.status = STATUS_EMPTY;
         end
         default: ;
      endcase
      o.unread_count = 7'(sh_count - sh_rd);
      expected_rsp.push_back(o);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("mismatch at response %0d: %s got 0x%0h expected 0x%0h",
               received, what, got, want);
   endtask

   // driver: one item per transfer, with a random gap before each
   int gap = 0;
   always @(posedge clock) begin
      logic [63:0] item;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_dispatch({5'd0, req_tdata, req_tuser});
            sent++;
            gap = $urandom_range(0, 3);
            if (gap == 0 && pending_items.size() > 0) begin
               item = pending_items.pop_front();
               req_tuser <= item[2:0];
               req_tdata <= item[58:3];
            end else begin
               req_tvalid <= 1'b0;
            end
         end else if (!req_tvalid) begin
            if (gap > 0) begin
               gap--;
            end else if (pending_items.size() > 0) begin
               item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= item[2:0];
               req_tdata <= item[58:3];
            end
         end
      end
   end

   // monitor: checks each response transfer, with a random stall after each
   int stall = 0;
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_rsp(rsp_tdata);
            received++;
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected response", 0, 0);
            end else begin
               want = expected_rsp.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.entry_type !== want.entry_type)
                  report_mismatch("entry_type", got.entry_type, want.entry_type);
               if (got.entry_priority !== want.entry_priority)
                  report_mismatch("entry_priority", got.entry_priority, want.entry_priority);
               if (got.entry_offset !== want.entry_offset)
                  report_mismatch("entry_offset", got.entry_offset, want.entry_offset);
               if (got.entry_size !== want.entry_size)
                  report_mismatch("entry_size", got.entry_size, want.entry_size);
               if (got.byte_out !== want.byte_out)
                  report_mismatch("byte_out", got.byte_out, want.byte_out);
               if (got.unread_count !== want.unread_count)
                  report_mismatch("unread_count", got.unread_count, want.unread_count);
            end
            stall = $urandom_range(0, 3);
            if (stall != 0 || hold_rsp) rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            if (stall > 0) stall--;
            else if (!hold_rsp) rsp_tready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   initial begin
      wait (sent > 300);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // stimulus; written bytes tracked so read_byte never hits an unwritten address
   int high_water = 0;
   int q_count = 0, q_committed = 0, q_staged = 0;

   task automatic add_item(input logic [63:0] w);
      kind_type k;
      k = kind_type'(w[2:0]);
      case (k)
         KIND_PAYLOAD_BYTE: if (q_committed + q_staged < PayBytes) begin
            q_staged++;
            if (q_committed + q_staged > high_water) high_water = q_committed + q_staged;
         end
         KIND_PUSH: begin
            if (q_count < Depth) begin
               q_committed += q_staged;
               q_count++;
            end
            q_staged = 0;
         end
         KIND_CLEAR: begin
            q_count = 0; q_committed = 0; q_staged = 0;
         end
         default: ;
      endcase
      pending_items.push_back(w);
   endtask

   task automatic add_read(input int addr);
      add_item(pack_item(KIND_READ_BYTE, 0, 0, 0, 0, addr[9:0]));
   endtask

   function automatic logic [15:0] rand_prio();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 7) - 4);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic add_rand_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         add_item(pack_item(KIND_PAYLOAD_BYTE, 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), rand_prio(),
                            6'($urandom_range(0, 63)), 10'($urandom_range(0, 1023))));
      else if (r < 58)
         add_item(pack_item(KIND_PUSH, 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), rand_prio(),
                            6'($urandom_range(0, 63)), 10'($urandom_range(0, 1023))));
      else if (r < 70)
         add_item(pack_item(KIND_POP, 0, 0, 0, 0, 0));
      else if (r < 80)
         add_item(pack_item(KIND_PEEK, 0, 0, 0, 6'($urandom_range(0, 63)), 0));
      else if (r < 86)
         add_item(pack_item(KIND_SORT, 0, 0, 0, 0, 0));
      else if (r < 87)
         add_item(pack_item(KIND_CLEAR, 0, 0, 0, 0, 0));
      else if (r < 88)
         add_item(pack_item(KIND_NONE, 8'($urandom_range(0, 255)), 0, 0, 0, 0));
      else if (high_water > 0)
         add_read($urandom_range(0, high_water - 1));
      else
         add_item(pack_item(KIND_POP, 0, 0, 0, 0, 0));
   endtask

   initial begin
      // directed: empty cases, extremes, stable sort with equal priorities
      add_item(pack_item(KIND_POP, 0, 0, 0, 0, 0));
      add_item(pack_item(KIND_PEEK, 0, 0, 0, 6'd63, 0));
      add_item(pack_item(KIND_SORT, 0, 0, 0, 0, 0));
      add_item(pack_item(KIND_PUSH, 0, 16'hffff, 16'h7fff, 0, 0));
      add_item(pack_item(KIND_PAYLOAD_BYTE, 8'hff, 0, 0, 0, 0));
      add_item(pack_item(KIND_PAYLOAD_BYTE, 8'h00, 0, 0, 0, 0));
      add_item(pack_item(KIND_PUSH, 0, 16'h0000, 16'h8000, 0, 0));
      add_item(pack_item(KIND_PAYLOAD_BYTE, 8'ha5, 0, 0, 0, 0));
      add_item(pack_item(KIND_PUSH, 0, 16'h1234, 16'h0005, 0, 0));
      add_item(pack_item(KIND_PUSH, 0, 16'h5678, 16'h0005, 0, 0));
      add_item(pack_item(KIND_PUSH, 0, 16'h9abc, 16'hfffb, 0, 0));
      add_item(pack_item(KIND_SORT, 0, 0, 0, 0, 0));
      add_item(pack_item(KIND_PEEK, 0, 0, 0, 6'd0, 0));
      add_item(pack_item(KIND_PEEK, 0, 0, 0, 6'd4, 0));
      add_item(pack_item(KIND_PEEK, 0, 0, 0, 6'd5, 0));
      add_item(pack_item(KIND_POP, 0, 0, 0, 0, 0));
      add_item(pack_item(KIND_PEEK, 0, 0, 0, 6'd0, 0));
      add_read(0); add_read(2);
      add_item(pack_item(KIND_NONE, 0, 0, 0, 0, 0));
      add_item(pack_item(KIND_CLEAR, 0, 0, 0, 0, 0));
      add_item(pack_item(KIND_POP, 0, 0, 0, 0, 0));
      add_read(1);
      // fill the entry store past its depth, then the payload memory past its end
      for (int i = 0; i < Depth + 2; i++)
         add_item(pack_item(KIND_PUSH, 0, i[15:0], rand_prio(), 0, 0));
      add_item(pack_item(KIND_SORT, 0, 0, 0, 0, 0));
      add_item(pack_item(KIND_PEEK, 0, 0, 0, 6'd63, 0));
      add_item(pack_item(KIND_CLEAR, 0, 0, 0, 0, 0));
      for (int i = 0; i < PayBytes + 2; i++)
         add_item(pack_item(KIND_PAYLOAD_BYTE, 8'($urandom_range(0, 255)), 0, 0, 0, 0));
      add_item(pack_item(KIND_PUSH, 0, 16'h00aa, 0, 0, 0));
      add_read(1023);
      add_item(pack_item(KIND_PEEK, 0, 0, 0, 6'd0, 0));
      add_item(pack_item(KIND_CLEAR, 0, 0, 0, 0, 0));
      for (int i = 0; i < 720; i++) add_rand_item();
      stim_done = 1'b1;
   end

   // hold reset at the start, then wait for drain
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_items.size() == 0 && !req_tvalid && expected_rsp.size() == 0);
      repeat (50) @(posedge clock);
      $display("items sent %0d, responses checked %0d", sent, received);
      $display("full-status hits %0d, sorts %0d", full_hits, sorts);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("priority_sorted_dispatch_queue_test: PASS");
      end else begin
         $display("priority_sorted_dispatch_queue_test: FAIL");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("timeout");
      $display("priority_sorted_dispatch_queue_test: FAIL");
      $finish;
   end
endmodule
`default_nettype wire

### priority_sorted_dispatch_queue.f
hdl/psdq_pkg.sv
hdl/psdq_ram.sv
hdl/priority_sorted_dispatch_queue.sv
hdl/psdq_checker.sv
tb/sv/priority_sorted_dispatch_queue_test.sv
